/* design/gcd_lcm_unit_defines.svh */
// Assertion helpers for the RTL, included by gcd_lcm_unit.sv. Each macro expects clk and arst_n in scope.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// A condition that must hold at every rising clock edge outside reset.
`define GLU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold whenever its antecedent holds.
`define GLU_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* design/glu_pkg.sv */
package glu_pkg;

	localparam int FIELD_WIDTH   = 32;
	localparam int ANSWER_WIDTH  = 64;
	localparam int OPERAND_WIDTH = 32;

	localparam logic MODE_LCM = 1'b0;
	localparam logic MODE_GCD = 1'b1;

	typedef struct packed {
		logic                   mode;
		logic [FIELD_WIDTH-1:0] first_value;
		logic [FIELD_WIDTH-1:0] second_value;
	} req_t;

	typedef struct packed {
		logic [ANSWER_WIDTH-1:0] answer;
		logic                    zero_operand;
	} rsp_t;

endpackage

/* design/glu_gcd.sv */
// Binary GCD: one halving or subtract-and-halve step per cycle, then the common
// power of two is restored by shifting left one place per cycle.
module glu_gcd #(
	parameter int W = glu_pkg::OPERAND_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int KW = $clog2(W);
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_REDUCE = 2'd1;
	localparam logic [1:0] PH_SHIFT  = 2'd2;

	logic [1:0]    phase_q;
	logic [W-1:0]  u_q;
	logic [W-1:0]  v_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  diff_uv;
	logic [W-1:0]  diff_vu;

	assign diff_uv = u_q - v_q;
	assign diff_vu = v_q - u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_REDUCE;
					end
				end
				PH_REDUCE: begin
					if (u_q == v_q) begin
						phase_q <= PH_SHIFT;
					end
				end
				PH_SHIFT: begin
					if (k_q == '0) begin
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Both operands stay nonzero, so the loop ends when they meet.
	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= a;
			v_q <= b;
			k_q <= '0;
		end else if (phase_q == PH_REDUCE && u_q != v_q) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q > v_q) begin
				u_q <= diff_uv >> 1;
			end else begin
				v_q <= diff_vu >> 1;
			end
		end else if (phase_q == PH_SHIFT && k_q != '0) begin
			u_q <= u_q << 1;
			k_q <= k_q - 1'b1;
		end
	end

	assign done   = (phase_q == PH_SHIFT) && (k_q == '0);
	assign result = u_q;

endmodule

/* design/glu_div.sv */
// Restoring divider, one quotient bit per cycle.
module glu_div #(
	parameter int W = glu_pkg::OPERAND_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  d_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
			cnt_q <= CW'(W - 1);
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/glu_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle.
module glu_mul #(
	parameter int W = glu_pkg::OPERAND_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   multiplier,
	input  logic [W-1:0]   multiplicand,
	output logic           done,
	output logic [2*W-1:0] product
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [W-1:0]  mc_q;
	logic [W:0]    sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The low half holds the unused multiplier bits and fills with product bits.
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q  <= '0;
			lo_q  <= multiplier;
			mc_q  <= multiplicand;
			cnt_q <= CW'(W - 1);
		end else if (busy_q) begin
			hi_q  <= sum[W:1];
			lo_q  <= {sum[0], lo_q[W-1:1]};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

/* design/gcd_lcm_unit.sv */
// Channel  | Signals                      | Direction
// request  | req_valid, req_stall, req    | in, stall driven here
// response | rsp_valid, rsp_stall, rsp    | out, stall driven by sink
//
// One item at a time. GCD: the result passes through the binary GCD reduction steps and the
// left shifts that restore k, the common power of two. LCM adds the serial divide and
// multiply. A zero operand skips all three units and goes straight to the hold state.
// The next request is
// taken the cycle after the result is loaded; the response register holds a result while
// rsp_stall is high, and reset clears all control state.
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit #(
	parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  glu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output glu_pkg::rsp_t rsp
);

	localparam int W  = OPERAND_WIDTH;
	localparam int AW = glu_pkg::ANSWER_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0]     state_q;
	logic           mode_q;
	logic [W-1:0]   a_q;
	logic [W-1:0]   b_q;
	logic [2*W-1:0] res_q;
	logic           err_q;
	logic           rsp_valid_q;
	glu_pkg::rsp_t  rsp_q;

	logic [W-1:0]   a_in;
	logic [W-1:0]   b_in;
	logic           accept;
	logic           zero_in;
	logic           gcd_start;
	logic           gcd_done;
	logic [W-1:0]   gcd_res;
	logic           div_start;
	logic           div_done;
	logic [W-1:0]   div_res;
	logic           mul_start;
	logic           mul_done;
	logic [2*W-1:0] mul_res;
	logic           load_rsp;

	assign a_in      = req.first_value[W-1:0];
	assign b_in      = req.second_value[W-1:0];
	assign req_stall = state_q != ST_IDLE;
	assign accept    = req_valid && !req_stall;
	assign zero_in   = (a_in == '0) || (b_in == '0);
	assign gcd_start = accept && !zero_in;
	assign div_start = (state_q == ST_GCD) && gcd_done && (mode_q == glu_pkg::MODE_LCM);
	assign mul_start = (state_q == ST_DIV) && div_done;
	assign load_rsp  = (state_q == ST_HOLD) && (!rsp_valid_q || !rsp_stall);

	glu_gcd #(.W(W)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (a_in),
		.b      (b_in),
		.done   (gcd_done),
		.result (gcd_res)
	);

	// lcm = (a / gcd) * b; the division is exact.
	glu_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q),
		.divisor  (gcd_res),
		.done     (div_done),
		.quotient (div_res)
	);

	glu_mul #(.W(W)) u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplier   (div_res),
		.multiplicand (b_q),
		.done         (mul_done),
		.product      (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= zero_in ? ST_HOLD : ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_done) begin
						state_q <= (mode_q == glu_pkg::MODE_GCD) ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			a_q    <= a_in;
			b_q    <= b_in;
			res_q  <= '0;
			err_q  <= zero_in;
		end else if (state_q == ST_GCD && gcd_done) begin
			res_q <= (2*W)'(gcd_res);
		end else if (state_q == ST_MUL && mul_done) begin
			res_q <= mul_res;
		end
		if (load_rsp) begin
			rsp_q.answer       <= AW'(res_q);
			rsp_q.zero_operand <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`GLU_ASSERT_IMPLIES(a_gcd_done_in_gcd, gcd_done, state_q == ST_GCD, "gcd done outside GCD state")
	`GLU_ASSERT_IMPLIES(a_div_done_in_div, div_done, state_q == ST_DIV, "div done outside DIV state")
	`GLU_ASSERT_IMPLIES(a_mul_done_in_mul, mul_done, state_q == ST_MUL, "mul done outside MUL state")
	`GLU_ASSERT_IMPLIES(a_err_zero_answer, rsp_valid && rsp.zero_operand, rsp.answer == '0,
		"zero operand transfer carries a nonzero answer")
	`GLU_ASSERT_IMPLIES(a_hold_blocks_req, state_q == ST_HOLD, req_stall && !gcd_done,
		"request taken while a result is pending")

endmodule

/* verif/glu_checker.sv */
module glu_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  glu_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  glu_pkg::rsp_t rsp,
	output int            pending,
	output int            fail_count
);

	glu_pkg::rsp_t expected_answers[$];
	glu_pkg::rsp_t oldest;

	function automatic glu_pkg::rsp_t predict_answer(input glu_pkg::req_t item);
		logic [63:0]   operand_mask;
		logic [63:0]   a;
		logic [63:0]   b;
		logic [63:0]   x;
		logic [63:0]   y;
		logic [63:0]   r;
		glu_pkg::rsp_t res;
		operand_mask = (64'd1 << glu_pkg::OPERAND_WIDTH) - 64'd1;
		a = 64'(item.first_value) & operand_mask;
		b = 64'(item.second_value) & operand_mask;
		res.answer = '0;
		res.zero_operand = 1'b1;
		if (a == 64'd0 || b == 64'd0) begin
			return res;
		end
		// Euclid's remainder loop; y ends up holding the divisor.
		x = a;
		y = b;
		r = x % y;
		while (r != 64'd0) begin
			x = y;
			y = r;
			r = x % y;
		end
		if (item.mode == glu_pkg::MODE_GCD) begin
			res.answer = y;
		end else begin
			res.answer = (a / y) * b;
		end
		res.zero_operand = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending <= 0;
			fail_count = 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_answers.push_back(predict_answer(req));
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_answers.size() == 0) begin
					if (fail_count < 10) begin
						$display("ERROR: result transfer with nothing expected: answer=%h zero_operand=%b",
							rsp.answer, rsp.zero_operand);
					end
					fail_count = fail_count + 1;
				end else begin
					oldest = expected_answers.pop_front();
					if (rsp.answer !== oldest.answer || rsp.zero_operand !== oldest.zero_operand) begin
						if (fail_count < 10) begin
							$display("ERROR: answer expected %h got %h, zero_operand expected %b got %b",
								oldest.answer, rsp.answer, oldest.zero_operand, rsp.zero_operand);
						end
						fail_count = fail_count + 1;
					end
				end
			end
			pending <= expected_answers.size();
		end
	end

endmodule

/* verif/tb_gcd_lcm_unit.sv */
module tb_gcd_lcm_unit;

	localparam int RANDOM_ITEMS = 1830;
	localparam int PAUSE_AT     = 900;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	glu_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	glu_pkg::rsp_t rsp;
	int            pending;
	int            fail_count;

	int           stall_run   = 0;
	stall_style_t stall_style = STALL_NONE;
	int           burst_left  = 0;

	logic [31:0] directed_first [12] = '{32'd0, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'd1,
		32'hFFFF_FFFF, 32'd4294967291, 32'd2971215073, 32'h8000_0000, 32'd12345, 32'd1,
		32'hFFFF_FFFE};
	logic [31:0] directed_second [12] = '{32'd5, 32'd0, 32'd0, 32'hFFFF_FFFF,
		32'hFFFF_FFFF, 32'd1, 32'd4294967279, 32'd1836311903, 32'h4000_0000, 32'd12345,
		32'd1, 32'h7FFF_FFFF};

	gcd_lcm_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	glu_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#32_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// The receiver switches between stall styles in stretches of random length.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_run <= $urandom_range(10, 300);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_style)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ~rsp_stall;
		endcase
	end

	function automatic glu_pkg::req_t make_operands();
		glu_pkg::req_t item;
		logic [31:0]   factor;
		logic [31:0]   span;
		item.mode = $urandom_range(0, 1) ? glu_pkg::MODE_GCD : glu_pkg::MODE_LCM;
		item.first_value = $urandom;
		item.second_value = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5: begin
				// Shared factor so that the divisor is not trivially one.
				factor = $urandom_range(2, 65535);
				span = 32'hFFFF_FFFF / factor;
				item.first_value = factor * $urandom_range(1, span);
				item.second_value = factor * $urandom_range(1, span);
			end
			6: begin
				if ($urandom_range(0, 2) == 0) begin
					item.first_value = '0;
				end
				if ($urandom_range(0, 1) == 0) begin
					item.second_value = '0;
				end else if (item.first_value != '0) begin
					item.first_value = '0;
				end
			end
			7: begin
				item.first_value = $urandom_range(1, 255);
				item.second_value = $urandom_range(1, 255);
			end
			8: begin
				item.first_value = 32'd1 << $urandom_range(0, 31);
				item.second_value = (32'd1 << $urandom_range(0, 31)) * $urandom_range(1, 3);
			end
			default: begin
				if (item.first_value == '0) begin
					item.first_value = 32'd3;
				end
				span = 32'hFFFF_FFFF / item.first_value;
				item.second_value = $urandom_range(0, 1) ? item.first_value :
					item.first_value * $urandom_range(1, span);
			end
		endcase
		return item;
	endfunction

	// Called right after a rising edge; returns at the edge of the transfer.
	task automatic send_item(input glu_pkg::req_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 20);
		end
		burst_left = burst_left - 1;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	initial begin
		glu_pkg::req_t item;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 12; i++) begin
			item.first_value = directed_first[i];
			item.second_value = directed_second[i];
			item.mode = glu_pkg::MODE_GCD;
			send_item(item);
			item.mode = glu_pkg::MODE_LCM;
			send_item(item);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == PAUSE_AT) begin
				// Let the block drain completely before the next transfer.
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				burst_left = 0;
			end
			send_item(make_operands());
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
